FILE: rtl/trmc_pkg.sv
// shared types, constants and row coding function for the tile row mask compressor
// no dependencies; used by trmc_ser and tile_row_mask_compressor_core
package trmc_pkg;

    localparam int unsigned ROW_BYTES = 4;
    localparam int unsigned MAX_WORDS = ROW_BYTES + 1;

    localparam logic [1:0] CODE_REPEAT  = 2'b00;
    localparam logic [1:0] CODE_LITERAL = 2'b01;
    localparam logic [1:0] CODE_ZERO    = 2'b10;
    localparam logic [1:0] CODE_ONES    = 2'b11;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] TERMINATOR = 8'h00;

    typedef logic [ROW_BYTES-1:0][7:0] t_row;
    typedef logic [ROW_BYTES-1:0] t_flags;
    typedef logic [$clog2(ROW_BYTES+1)-1:0] t_count;
    typedef logic [$clog2(MAX_WORDS+1)-1:0] t_remain;

    typedef struct packed {
        logic   finish;
        logic   [7:0] mask;
        t_row   lits;
        t_count n_lits;
    } t_coded;

    // byte 0 of the row sits in mask bits 7:6
    function automatic t_coded code_row(input t_row row, input t_flags is_zero,
                                        input t_flags is_ones, input logic finish);
        t_coded     res;
        logic       have_lit;
        logic [7:0] lit_val;
        logic [1:0] code;
        res      = '0;
        have_lit = 1'b0;
        lit_val  = BYTE_ZERO;
        res.finish = finish;
        for (int i = 0; i < ROW_BYTES; i++) begin
            if (is_zero[i]) begin
                code = CODE_ZERO;
            end else if (is_ones[i]) begin
                code = CODE_ONES;
            end else if (have_lit && row[i] == lit_val) begin
                code = CODE_REPEAT;
            end else begin
                code = CODE_LITERAL;
                have_lit = 1'b1;
                lit_val  = row[i];
                res.lits[res.n_lits[$clog2(ROW_BYTES)-1:0]] = row[i];
                res.n_lits = res.n_lits + t_count'(1);
            end
            res.mask[7-2*i -: 2] = code;
        end
        return res;
    endfunction

endpackage

FILE: rtl/tile_row_mask_compressor_core.sv
// top level of the tile row mask compressor: input register, coding stage, serialiser
// depends on trmc_pkg and trmc_ser
//
// channel  direction  handshake            word
// input    in         start && !busy       i_row_byte_a..d, i_finish
// result   out        o_strobe (no stall)  o_out_byte, o_last_of_run
//
// three stages: byte classify, row coding, serialiser; synchronous active-low reset empties all
// first result word follows its input word through classify, coding and serialiser registers
// a row gives 1 to 5 result words, one per cycle; a finish item gives one
// rate is set by the one-word result port; a row loads as the prior row's last word goes out
// busy when classify and coding stages both hold a word and the serialiser has over one left

module tile_row_mask_compressor_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_row_byte_a,
    input  logic [7:0] i_row_byte_b,
    input  logic [7:0] i_row_byte_c,
    input  logic [7:0] i_row_byte_d,
    input  logic       i_finish,
    output logic       o_strobe,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic              r_s1_vld;
    trmc_pkg::t_row    r_s1_row;
    trmc_pkg::t_flags  r_s1_zero;
    trmc_pkg::t_flags  r_s1_ones;
    logic              r_s1_finish;
    logic              r_s2_vld;
    trmc_pkg::t_coded  r_s2_coded;
    trmc_pkg::t_row    n_s1_row;
    logic              ser_free;
    logic              s1_adv;

    assign n_s1_row = {i_row_byte_d, i_row_byte_c, i_row_byte_b, i_row_byte_a};
    assign s1_adv   = !r_s2_vld || ser_free;
    assign busy     = r_s1_vld && !s1_adv;

    // stage 1: capture and classify
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!busy) begin
            r_s1_vld <= start;
        end
        if (start && !busy) begin
            r_s1_row    <= n_s1_row;
            r_s1_finish <= i_finish;
            for (int i = 0; i < trmc_pkg::ROW_BYTES; i++) begin
                r_s1_zero[i] <= (n_s1_row[i] == trmc_pkg::BYTE_ZERO);
                r_s1_ones[i] <= (n_s1_row[i] == trmc_pkg::BYTE_ONES);
            end
        end
    end

    // stage 2: mask and literal list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s2_vld <= r_s1_vld;
        end
        if (s1_adv && r_s1_vld) begin
            r_s2_coded <= trmc_pkg::code_row(r_s1_row, r_s1_zero, r_s1_ones, r_s1_finish);
        end
    end

    // stage 3: serialiser
    trmc_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (r_s2_vld),
        .i_coded       (r_s2_coded),
        .o_free        (ser_free),
        .o_strobe      (o_strobe),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: rtl/trmc_ser.sv
// output serialiser: turns one coded row into mask and literal words, or a finish item into a terminator, one a cycle
// depends on trmc_pkg
module trmc_ser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  trmc_pkg::t_coded i_coded,
    output logic             o_free,
    output logic             o_strobe,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run
);

    logic [trmc_pkg::MAX_WORDS-1:0][7:0] r_q;
    logic [trmc_pkg::MAX_WORDS-1:0][7:0] n_q;
    trmc_pkg::t_remain r_rem;
    trmc_pkg::t_remain n_rem;

    assign o_strobe      = (r_rem != '0);
    assign o_last_of_run = (r_rem == trmc_pkg::t_remain'(1));
    assign o_out_byte    = r_q[0];
    assign o_free        = (r_rem == '0) || o_last_of_run;

    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        if (r_rem != '0) begin
            for (int k = 0; k < trmc_pkg::MAX_WORDS - 1; k++) begin
                n_q[k] = r_q[k+1];
            end
            n_rem = r_rem - trmc_pkg::t_remain'(1);
        end
        if (i_load && o_free) begin
            if (i_coded.finish) begin
                n_q[0] = trmc_pkg::TERMINATOR;
                n_rem  = trmc_pkg::t_remain'(1);
            end else begin
                n_q[0] = i_coded.mask;
                for (int k = 0; k < trmc_pkg::ROW_BYTES; k++) begin
                    n_q[k+1] = i_coded.lits[k];
                end
                n_rem = trmc_pkg::t_remain'(i_coded.n_lits) + trmc_pkg::t_remain'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

endmodule

FILE: test/tile_row_mask_compressor_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for tile_row_mask_compressor_core: directed and random rows and
// finish markers, with a behavioural row coder in a small scoreboard class
// depends on trmc_pkg and the compressor rtl
module tile_row_mask_compressor_core_tb;

    localparam int unsigned CYCLE_LIMIT = 60000;
    localparam int unsigned RANDOM_ITEMS = 104;
    localparam int unsigned MAX_SHOWN = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_word;

    class trmc_stream_board;
        t_word       pending_words[$];
        int unsigned errors;
        int unsigned words_checked;

        function new();
            errors = 0;
            words_checked = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_SHOWN) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        // codes one row into its mask word and literal words, or a finish item into one terminator word
        function void note_row(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
                               logic fin);
            logic [7:0] row_bytes[trmc_pkg::ROW_BYTES];
            logic [7:0] lit_words[$];
            logic [7:0] mask;
            logic [7:0] lit_val;
            logic       have_lit;
            logic [1:0] code;
            t_word      w;
            if (fin) begin
                w.value = trmc_pkg::TERMINATOR;
                w.last = 1'b1;
                pending_words.push_back(w);
                return;
            end
            row_bytes[0] = a;
            row_bytes[1] = b;
            row_bytes[2] = c;
            row_bytes[3] = d;
            mask = '0;
            lit_val = '0;
            have_lit = 1'b0;
            for (int i = 0; i < trmc_pkg::ROW_BYTES; i++) begin
                if (row_bytes[i] == trmc_pkg::BYTE_ZERO) begin
                    code = trmc_pkg::CODE_ZERO;
                end else if (row_bytes[i] == trmc_pkg::BYTE_ONES) begin
                    code = trmc_pkg::CODE_ONES;
                end else if (have_lit && row_bytes[i] == lit_val) begin
                    code = trmc_pkg::CODE_REPEAT;
                end else begin
                    code = trmc_pkg::CODE_LITERAL;
                    have_lit = 1'b1;
                    lit_val = row_bytes[i];
                    lit_words.push_back(row_bytes[i]);
                end
                mask[7 - 2 * i -: 2] = code;
            end
            w.value = mask;
            w.last = (lit_words.size() == 0);
            pending_words.push_back(w);
            foreach (lit_words[k]) begin
                w.value = lit_words[k];
                w.last = (k == lit_words.size() - 1);
                pending_words.push_back(w);
            end
        endfunction

        function void check_word(logic [7:0] value, logic last);
            t_word w;
            words_checked++;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word %02h last %0b", value, last));
                return;
            end
            w = pending_words.pop_front();
            if (value !== w.value) begin
                report($sformatf("out_byte expected %02h got %02h", w.value, value));
            end
            if (last !== w.last) begin
                report($sformatf("last_of_run expected %0b got %0b (byte %02h)",
                                 w.last, last, w.value));
            end
        endfunction

        function int unsigned pending();
            return pending_words.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] i_row_byte_a = '0;
    logic [7:0] i_row_byte_b = '0;
    logic [7:0] i_row_byte_c = '0;
    logic [7:0] i_row_byte_d = '0;
    logic       i_finish = 1'b0;
    logic       o_strobe;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    trmc_stream_board board = new();
    int unsigned      cycle_count = 0;
    int unsigned      rows_sent = 0;
    int unsigned      finishes_sent = 0;
    bit               allow_gaps = 1'b1;

    tile_row_mask_compressor_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_row_byte_a  (i_row_byte_a),
        .i_row_byte_b  (i_row_byte_b),
        .i_row_byte_c  (i_row_byte_c),
        .i_row_byte_d  (i_row_byte_d),
        .i_finish      (i_finish),
        .o_strobe      (o_strobe),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_strobe) begin
                board.check_word(o_out_byte, o_last_of_run);
            end
            if (start && !busy) begin
                board.note_row(i_row_byte_a, i_row_byte_b, i_row_byte_c, i_row_byte_d,
                               i_finish);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, board.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d,
                             logic fin);
        i_row_byte_a <= a;
        i_row_byte_b <= b;
        i_row_byte_c <= c;
        i_row_byte_d <= d;
        i_finish <= fin;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (fin) begin
            finishes_sent++;
        end else begin
            rows_sent++;
        end
        if (allow_gaps && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_byte(logic [7:0] prev_lit, bit have_prev);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            return trmc_pkg::BYTE_ZERO;
        end else if (sel < 4) begin
            return trmc_pkg::BYTE_ONES;
        end else if (sel < 6 && have_prev) begin
            return prev_lit;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_item();
        logic [7:0] row_bytes[trmc_pkg::ROW_BYTES];
        logic [7:0] prev_lit;
        bit         have_prev;
        have_prev = 1'b0;
        prev_lit = '0;
        for (int i = 0; i < trmc_pkg::ROW_BYTES; i++) begin
            row_bytes[i] = pick_byte(prev_lit, have_prev);
            if (row_bytes[i] != trmc_pkg::BYTE_ZERO && row_bytes[i] != trmc_pkg::BYTE_ONES) begin
                prev_lit = row_bytes[i];
                have_prev = 1'b1;
            end
        end
        send_word(row_bytes[0], row_bytes[1], row_bytes[2], row_bytes[3],
                  $urandom_range(0, 9) == 0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows and finish markers
        send_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_word(8'h5A, 8'h5A, 8'h5A, 8'h5A, 1'b0);
        send_word(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
        send_word(8'h12, 8'h34, 8'h12, 8'h34, 1'b0);
        send_word(8'h12, 8'h00, 8'h12, 8'hFF, 1'b0);
        send_word(8'h01, 8'hFE, 8'h80, 8'h7F, 1'b0);
        send_word(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
        send_word(8'hFF, 8'h00, 8'h33, 8'h33, 1'b0);
        send_word(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
        send_word(8'hA5, 8'hC3, 8'h3C, 8'h99, 1'b1);
        send_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_word(8'h77, 8'hFF, 8'h77, 8'h00, 1'b0);
        send_word(8'h00, 8'h00, 8'h00, 8'h01, 1'b0);
        send_word(8'hFE, 8'hFE, 8'h01, 8'h01, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - 30) begin
                allow_gaps = 1'b0;
            end
            send_random_item();
        end
        start <= 1'b0;

        while (board.pending() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("sent %0d rows and %0d finish markers, checked %0d output words",
                 rows_sent, finishes_sent, board.words_checked);
        $display("%0d mismatches, %0d words never produced", board.errors, board.pending());
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
